// File: src/elliptic_window_moving_average_assert.svh
`ifndef ELLIPTIC_WINDOW_MOVING_AVERAGE_ASSERT_SVH
`define ELLIPTIC_WINDOW_MOVING_AVERAGE_ASSERT_SVH

// check a property on every clock edge outside reset
`define EWMA_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that a condition never holds outside reset
`define EWMA_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: src/ewma_pkg.sv
package ewma_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W     = 33;
   localparam int ROT_W      = 50;
   localparam int T_W        = 96;
   localparam int SQ_W       = 192;
   localparam int SUM_W      = CNT_W + 32;
   localparam int MAG_W      = SUM_W - 1;
   localparam int ENTRY_W    = 96;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_RADIUS_ONE = 3'd0,
      REG_RADIUS_TWO = 3'd1,
      REG_COS_ANGLE  = 3'd2,
      REG_SIN_ANGLE  = 3'd3,
      REG_MIN_POINTS = 3'd4,
      REG_NODATA     = 3'd5
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BND_MUL,
      ST_BND_SQ,
      ST_PT_RD,
      ST_PT_DIFF,
      ST_ROT,
      ST_AX_MUL,
      ST_AX_SQ,
      ST_CMP,
      ST_FIN,
      ST_DIV
   } state_type;

endpackage

// File: src/elliptic_window_moving_average.sv
// Elliptic window moving average over a store of up to 1024 scattered points.
// Input: start/busy command port; a transfer happens when start is high and busy
// is low. Opcode clear and load finish in the cycle of the transfer (busy stays
// low), a load beyond capacity is dropped and sets the overflow flag.
// Opcode query walks every stored point through one point memory, rotates the
// offset, squares the scaled axes with a shared 96-bit squaring unit (one 32x32
// multiplier) and tests the ellipse exactly, then divides the z sum by the count
// with a bit-serial divider, or gives nodata when too few points (or none) hit.
// The squaring unit, used twice per point, dominates the time spent per point.
// Output: rsp_valid pulses for one cycle with node value, count, empty and
// overflow flags; the receiver cannot stall and must take it then.
// Configuration: csr_wr_en writes register csr_index at once; user must write only while idle (not enforced).
// Reset: the store is empty, overflow clear, registers at their defaults.
// Unused opcode 3 is taken and ignored.
`include "elliptic_window_moving_average_assert.svh"

module elliptic_window_moving_average import ewma_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_sample_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_node_value,
   output logic [CNT_W-1:0]   rsp_hit_count,
   output logic               rsp_is_empty,
   output logic               rsp_load_overflow,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data
);

   state_type state_ff, state_in;

   logic [31:0]               r1_ff, r2_ff;
   logic signed [15:0]        cos_ff, sin_ff;
   logic [CNT_W-1:0]          minp_ff;
   logic signed [31:0]        nodata_ff;

   logic [CNT_W-1:0]          total_ff, idx_ff, hits_ff;
   logic                      dropped_ff;
   logic signed [31:0]        cx_ff, cy_ff, z_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff;
   logic signed [ROT_W-1:0]   rx_ff, ry_ff;
   logic [1:0]                step_ff;
   logic                      axis_ff, half_ff;
   logic [T_W-1:0]            t_ff;
   logic [SQ_W-1:0]           bound_ff, sa_ff, tot_ff;
   logic signed [SUM_W-1:0]   sum_ff;

   logic                      rsp_valid_ff;
   logic signed [31:0]        rsp_value_ff;
   logic [CNT_W-1:0]          rsp_count_ff;
   logic                      rsp_empty_ff, rsp_ovf_ff;

   logic                      accept;
   logic                      ram_wr, ram_rd;
   logic [ENTRY_W-1:0]        ram_q;
   logic signed [31:0]        rd_x, rd_y;
   logic signed [DIFF_W-1:0]  rot_a;
   logic signed [15:0]        rot_b;
   logic signed [ROT_W-1:0]   rot_p;
   logic [ROT_W-1:0]          mag;
   logic [31:0]               mul_a, mul_b;
   logic [63:0]               mul_p;
   logic                      sq_go, sq_run, sq_done;
   logic [SQ_W-1:0]           sq_res;
   logic                      div_go, div_run, div_done;
   logic [MAG_W-1:0]          div_q, sum_mag;
   logic                      is_empty;
   logic                      last_point;

   assign accept   = start && !busy;
   assign busy     = state_ff != ST_IDLE;
   assign ram_wr   = accept && req_opcode == OP_LOAD && total_ff < CNT_W'(MAX_POINTS);
   assign ram_rd   = state_ff == ST_PT_RD;
   assign rd_x     = ram_q[31:0];
   assign rd_y     = ram_q[63:32];

   ewma_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (total_ff[ADDR_W-1:0]),
      .wr_data ({req_sample_z, req_pos_y, req_pos_x}),
      .rd_en   (ram_rd),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   always_comb begin
      case (step_ff)
         2'd0: begin rot_a = dx_ff; rot_b = cos_ff; end
         2'd1: begin rot_a = dy_ff; rot_b = sin_ff; end
         2'd2: begin rot_a = dy_ff; rot_b = cos_ff; end
         default: begin rot_a = dx_ff; rot_b = sin_ff; end
      endcase
      rot_p = ROT_W'(rot_a) * ROT_W'(rot_b);
      if (axis_ff) begin
         mag = ry_ff[ROT_W-1] ? ROT_W'(-ry_ff) : ROT_W'(ry_ff);
      end else begin
         mag = rx_ff[ROT_W-1] ? ROT_W'(-rx_ff) : ROT_W'(rx_ff);
      end
      if (state_ff == ST_BND_MUL) begin
         mul_a = r1_ff;
         mul_b = r2_ff;
      end else begin
         mul_a = half_ff ? 32'(mag[ROT_W-1:32]) : mag[31:0];
         mul_b = axis_ff ? r1_ff : r2_ff;
      end
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   assign sq_go      = (state_ff == ST_BND_SQ || state_ff == ST_AX_SQ) && !sq_run && !sq_done;
   assign div_go     = state_ff == ST_DIV && !div_run && !div_done;
   assign sum_mag    = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
   assign is_empty   = hits_ff == '0 || hits_ff < minp_ff;
   assign last_point = idx_ff + CNT_W'(1) == total_ff;

   ewma_sq u_sq (
      .clock   (clock),
      .reset   (reset),
      .go      (sq_go),
      .operand (t_ff),
      .running (sq_run),
      .done    (sq_done),
      .square  (sq_res)
   );

   ewma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (sum_mag),
      .divisor  (hits_ff),
      .running  (div_run),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (accept && req_opcode == OP_QUERY) state_in = ST_BND_MUL;
         ST_BND_MUL: state_in = ST_BND_SQ;
         ST_BND_SQ:  if (sq_done) state_in = (total_ff == '0) ? ST_FIN : ST_PT_RD;
         ST_PT_RD:   state_in = ST_PT_DIFF;
         ST_PT_DIFF: state_in = ST_ROT;
         ST_ROT:     if (step_ff == 2'd3) state_in = ST_AX_MUL;
         ST_AX_MUL:  if (half_ff) state_in = ST_AX_SQ;
         ST_AX_SQ:   if (sq_done) state_in = axis_ff ? ST_CMP : ST_AX_MUL;
         ST_CMP:     state_in = last_point ? ST_FIN : ST_PT_RD;
         ST_FIN:     state_in = is_empty ? ST_IDLE : ST_DIV;
         ST_DIV:     if (div_done) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_ff     <= 32'd65536;
         r2_ff     <= 32'd65536;
         cos_ff    <= 16'sd16384;
         sin_ff    <= '0;
         minp_ff   <= '0;
         nodata_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_RADIUS_ONE: r1_ff     <= csr_wr_data;
            REG_RADIUS_TWO: r2_ff     <= csr_wr_data;
            REG_COS_ANGLE:  cos_ff    <= csr_wr_data[15:0];
            REG_SIN_ANGLE:  sin_ff    <= csr_wr_data[15:0];
            REG_MIN_POINTS: minp_ff   <= csr_wr_data[CNT_W-1:0];
            REG_NODATA:     nodata_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (accept) begin
            case (req_opcode)
               OP_CLEAR: begin
                  total_ff   <= '0;
                  dropped_ff <= 1'b0;
               end
               OP_LOAD: begin
                  if (ram_wr) begin
                     total_ff <= total_ff + CNT_W'(1);
                  end else begin
                     dropped_ff <= 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == ST_FIN && is_empty) begin
            rsp_valid_ff <= 1'b1;
         end
         if (state_ff == ST_DIV && div_done) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cx_ff   <= req_pos_x;
            cy_ff   <= req_pos_y;
            idx_ff  <= '0;
            hits_ff <= '0;
            sum_ff  <= '0;
         end
         ST_BND_MUL: t_ff <= T_W'(mul_p) << 14;
         ST_BND_SQ:  if (sq_done) bound_ff <= sq_res;
         ST_PT_DIFF: begin
            dx_ff   <= DIFF_W'(rd_x) - DIFF_W'(cx_ff);
            dy_ff   <= DIFF_W'(rd_y) - DIFF_W'(cy_ff);
            z_ff    <= ram_q[95:64];
            step_ff <= 2'd0;
         end
         ST_ROT: begin
            case (step_ff)
               2'd0: rx_ff <= rot_p;
               2'd1: rx_ff <= rx_ff + rot_p;
               2'd2: ry_ff <= rot_p;
               default: ry_ff <= ry_ff - rot_p;
            endcase
            step_ff <= step_ff + 2'd1;
            axis_ff <= 1'b0;
            half_ff <= 1'b0;
         end
         ST_AX_MUL: begin
            if (half_ff) begin
               t_ff <= t_ff + (T_W'(mul_p) << 32);
            end else begin
               t_ff <= T_W'(mul_p);
            end
            half_ff <= 1'b1;
         end
         ST_AX_SQ: begin
            if (sq_done) begin
               if (axis_ff) begin
                  tot_ff <= sa_ff + sq_res;
               end else begin
                  sa_ff   <= sq_res;
                  axis_ff <= 1'b1;
                  half_ff <= 1'b0;
               end
            end
         end
         ST_CMP: begin
            if (tot_ff <= bound_ff) begin
               sum_ff  <= sum_ff + SUM_W'(z_ff);
               hits_ff <= hits_ff + CNT_W'(1);
            end
            idx_ff <= idx_ff + CNT_W'(1);
         end
         ST_FIN: begin
            rsp_value_ff <= nodata_ff;
            rsp_count_ff <= hits_ff;
            rsp_empty_ff <= is_empty;
            rsp_ovf_ff   <= dropped_ff;
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_value_ff <= sum_ff[SUM_W-1] ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_node_value    = rsp_value_ff;
   assign rsp_hit_count     = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_load_overflow = rsp_ovf_ff;

   `EWMA_CHECK(a_rsp_after_query, rsp_valid |-> $past(state_ff != ST_IDLE), "result without query")
   `EWMA_NEVER(a_hits_bound, hits_ff > total_ff, "hit count above point total")
   `EWMA_CHECK(a_rsp_count, rsp_valid |-> (rsp_is_empty || rsp_hit_count != '0), "mean of no points")

endmodule

// File: src/ewma_ram.sv
module ewma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/ewma_sq.sv
module ewma_sq import ewma_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  logic [T_W-1:0]  operand,
   output logic            running,
   output logic            done,
   output logic [SQ_W-1:0] square
);

   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [1:0]      i_ff, i_in, j_ff, j_in;
   logic [T_W-1:0]  op_ff, op_in;
   logic [SQ_W-1:0] acc_ff, acc_in;
   logic [31:0]     limb_a, limb_b;
   logic [63:0]     prod;
   logic [2:0]      shift;

   always_comb begin
      limb_a  = op_ff[{i_ff, 5'b0} +: 32];
      limb_b  = op_ff[{j_ff, 5'b0} +: 32];
      prod    = 64'(limb_a) * 64'(limb_b);
      shift   = 3'(i_ff) + 3'(j_ff);
      run_in  = run_ff;
      done_in = 1'b0;
      i_in    = i_ff;
      j_in    = j_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      if (!run_ff) begin
         if (go && !done_ff) begin
            run_in = 1'b1;
            i_in   = 2'd0;
            j_in   = 2'd0;
            op_in  = operand;
            acc_in = '0;
         end
      end else begin
         acc_in = acc_ff + (SQ_W'(prod) << {shift, 5'b0});
         if (j_ff == 2'd2) begin
            j_in = 2'd0;
            i_in = i_ff + 2'd1;
            if (i_ff == 2'd2) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            j_in = j_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= 2'd0;
         j_ff    <= 2'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
      end
      op_ff  <= op_in;
      acc_ff <= acc_in;
   end

   assign running = run_ff;
   assign done    = done_ff;
   assign square  = acc_ff;

endmodule

// File: src/ewma_div.sv
module ewma_div import ewma_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [MAG_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             running,
   output logic             done,
   output logic [MAG_W-1:0] quotient
);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [CNT_W:0]   trial, diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[MAG_W-1]};
      diff    = trial - (CNT_W + 1)'(divisor);
      fits    = trial >= (CNT_W + 1)'(divisor);
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (!run_ff) begin
         if (go && !done_ff) begin
            run_in = 1'b1;
            cnt_in = '0;
            rem_in = '0;
            quo_in = dividend;
         end
      end else begin
         rem_in = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in = {quo_ff[MAG_W-2:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(MAG_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign running  = run_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
